FILE: rtl/sip_pkg.sv
// Package for the segment intersection pipeline: payload structs and the
// fixed-point multiply. It has no dependencies.
package sip_pkg;

	typedef logic signed [31:0] coord_t;

	// One segment pair request.
	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_end_x;
		coord_t b_end_y;
		logic   touch_counts;
		logic   range_prefilter;
	} seg_pair_t;

	// One result request.
	typedef struct packed {
		logic   hit;
		coord_t cross_x;
		coord_t cross_y;
		logic   degenerate;
	} result_t;

	// Front end to solver: decision and line coefficients.
	typedef struct packed {
		logic   hit;
		coord_t ca;
		coord_t cb;
		coord_t dxa;
		coord_t dya;
		coord_t dxb;
		coord_t dyb;
	} line_coef_t;

	// Solver to divider: numerators and determinant.
	typedef struct packed {
		logic   hit;
		logic   degenerate;
		coord_t nx;
		coord_t ny;
		coord_t det;
	} solve_t;

	// Rounded fixed-point multiply, wrapped to 32 bits.
	function automatic coord_t fx_mul(coord_t a, coord_t b, int frac);
		logic signed [63:0] p;
		logic signed [63:0] rnd;
		p   = 64'(a) * 64'(b);
		rnd = (frac > 0) ? (64'sd1 <<< (frac - 1)) : 64'sd0;
		p   = (p + rnd) >>> frac;
		return p[31:0];
	endfunction

endpackage

FILE: rtl/sip_chan_if.sv
// Valid/ready channel interface carrying one payload struct.
// The payload type is given at instantiation, normally from sip_pkg.
interface sip_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sip_front.sv
// Front end: differences and prefilter, orientation and coefficient
// multiplies, then the crossing decision. Three stages. Uses sip_pkg.
module sip_front
	import sip_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	sip_chan_if.sink    seg,
	output logic        out_valid,
	input  logic        out_ready,
	output line_coef_t  out_data
);

	typedef struct packed {
		coord_t e_ax, e_ay, pb0x, pb0y, pb1x, pb1y;
		coord_t e_bx, e_by, pa0x, pa0y, pa1x, pa1y;
		coord_t dxa, dxb;
		coord_t ax0, ay0, bx0, by0;
		logic   incl;
		logic   rejected;
	} s1_t;

	typedef struct packed {
		coord_t ma0, ma1, ma2, ma3;
		coord_t mb0, mb1, mb2, mb3;
		coord_t ca_p, ca_q, cb_p, cb_q;
		coord_t dxa, dya, dxb, dyb;
		logic   incl;
		logic   rejected;
	} s2_t;

	s1_t        data_s1;
	s2_t        data_s2;
	line_coef_t data_s3;
	logic       v_s1, v_s2, v_s3;
	logic       en1, en2, en3;

	// Each stage moves when it is empty or the next one moves.
	assign en3       = !v_s3 || out_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign seg.ready = en1;
	assign out_valid = v_s3;
	assign out_data  = data_s3;

	// True when the two extents on one axis do not overlap.
	function automatic logic apart(coord_t a0, coord_t a1, coord_t b0, coord_t b1);
		coord_t amin, amax, bmin, bmax;
		amin = (a0 < a1) ? a0 : a1;
		amax = (a0 < a1) ? a1 : a0;
		bmin = (b0 < b1) ? b0 : b1;
		bmax = (b0 < b1) ? b1 : b0;
		return (amax < bmin) || (amin > bmax);
	endfunction

	// Stage one: all operand differences and the prefilter.
	s1_t nxt1;
	always_comb begin
		seg_pair_t d;
		d         = seg.data;
		nxt1.e_ax = d.a_end_x - d.a_start_x;
		nxt1.e_ay = d.a_end_y - d.a_start_y;
		nxt1.pb0x = d.b_start_x - d.a_start_x;
		nxt1.pb0y = d.b_start_y - d.a_start_y;
		nxt1.pb1x = d.b_end_x - d.a_start_x;
		nxt1.pb1y = d.b_end_y - d.a_start_y;
		nxt1.e_bx = d.b_end_x - d.b_start_x;
		nxt1.e_by = d.b_end_y - d.b_start_y;
		nxt1.pa0x = d.a_start_x - d.b_start_x;
		nxt1.pa0y = d.a_start_y - d.b_start_y;
		nxt1.pa1x = d.a_end_x - d.b_start_x;
		nxt1.pa1y = d.a_end_y - d.b_start_y;
		nxt1.dxa  = d.a_start_x - d.a_end_x;
		nxt1.dxb  = d.b_start_x - d.b_end_x;
		nxt1.ax0  = d.a_start_x;
		nxt1.ay0  = d.a_start_y;
		nxt1.bx0  = d.b_start_x;
		nxt1.by0  = d.b_start_y;
		nxt1.incl = d.touch_counts;
		nxt1.rejected = d.range_prefilter &&
			(apart(d.a_start_x, d.a_end_x, d.b_start_x, d.b_end_x) ||
			 apart(d.a_start_y, d.a_end_y, d.b_start_y, d.b_end_y));
	end

	// Stage two: twelve rounded multiplies.
	s2_t nxt2;
	always_comb begin
		nxt2.ma0  = fx_mul(data_s1.e_ax, data_s1.pb0y, FRAC_BITS);
		nxt2.ma1  = fx_mul(data_s1.e_ay, data_s1.pb0x, FRAC_BITS);
		nxt2.ma2  = fx_mul(data_s1.e_ax, data_s1.pb1y, FRAC_BITS);
		nxt2.ma3  = fx_mul(data_s1.e_ay, data_s1.pb1x, FRAC_BITS);
		nxt2.mb0  = fx_mul(data_s1.e_bx, data_s1.pa0y, FRAC_BITS);
		nxt2.mb1  = fx_mul(data_s1.e_by, data_s1.pa0x, FRAC_BITS);
		nxt2.mb2  = fx_mul(data_s1.e_bx, data_s1.pa1y, FRAC_BITS);
		nxt2.mb3  = fx_mul(data_s1.e_by, data_s1.pa1x, FRAC_BITS);
		nxt2.ca_p = fx_mul(data_s1.e_ay, data_s1.ax0, FRAC_BITS);
		nxt2.ca_q = fx_mul(data_s1.dxa, data_s1.ay0, FRAC_BITS);
		nxt2.cb_p = fx_mul(data_s1.e_by, data_s1.bx0, FRAC_BITS);
		nxt2.cb_q = fx_mul(data_s1.dxb, data_s1.by0, FRAC_BITS);
		nxt2.dxa  = data_s1.dxa;
		nxt2.dya  = data_s1.e_ay;
		nxt2.dxb  = data_s1.dxb;
		nxt2.dyb  = data_s1.e_by;
		nxt2.incl = data_s1.incl;
		nxt2.rejected = data_s1.rejected;
	end

	// Stage three: orientation signs, crossing decision and coefficients.
	line_coef_t nxt3;
	always_comb begin
		coord_t ca0, ca1, cb0, cb1;
		logic   pa_pos, pa_zero, pb_pos, pb_zero, reject;
		ca0 = data_s2.ma0 - data_s2.ma1;
		ca1 = data_s2.ma2 - data_s2.ma3;
		cb0 = data_s2.mb0 - data_s2.mb1;
		cb1 = data_s2.mb2 - data_s2.mb3;
		pa_zero = (ca0 == 0) || (ca1 == 0);
		pa_pos  = !pa_zero && ((ca0 < 0) == (ca1 < 0));
		pb_zero = (cb0 == 0) || (cb1 == 0);
		pb_pos  = !pb_zero && ((cb0 < 0) == (cb1 < 0));
		if (data_s2.incl) begin
			reject = pa_pos || pb_pos;
		end else begin
			reject = pa_pos || pa_zero || pb_pos || pb_zero;
		end
		nxt3.hit = !data_s2.rejected && !reject;
		nxt3.ca  = -(data_s2.ca_p + data_s2.ca_q);
		nxt3.cb  = -(data_s2.cb_p + data_s2.cb_q);
		nxt3.dxa = data_s2.dxa;
		nxt3.dya = data_s2.dya;
		nxt3.dxb = data_s2.dxb;
		nxt3.dyb = data_s2.dyb;
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= seg.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en1) data_s1 <= nxt1;
		if (en2) data_s2 <= nxt2;
		if (en3) data_s3 <= nxt3;
	end

endmodule

FILE: rtl/sip_solve.sv
// Line solver: six rounded multiplies, then numerators and determinant.
// Two stages. Uses sip_pkg.
module sip_solve
	import sip_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  line_coef_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output solve_t     out_data
);

	typedef struct packed {
		logic   hit;
		coord_t p_nx0, p_nx1, p_ny0, p_ny1, p_d0, p_d1;
	} s4_t;

	s4_t    data_s4;
	solve_t data_s5;
	logic   v_s4, v_s5;
	logic   en4, en5;

	assign en5       = !v_s5 || out_ready;
	assign en4       = !v_s4 || en5;
	assign in_ready  = en4;
	assign out_valid = v_s5;
	assign out_data  = data_s5;

	// Stage four: products for the cross terms.
	s4_t nxt4;
	always_comb begin
		nxt4.hit   = in_data.hit;
		nxt4.p_nx0 = fx_mul(in_data.ca, in_data.dxb, FRAC_BITS);
		nxt4.p_nx1 = fx_mul(in_data.cb, in_data.dxa, FRAC_BITS);
		nxt4.p_ny0 = fx_mul(in_data.dya, in_data.cb, FRAC_BITS);
		nxt4.p_ny1 = fx_mul(in_data.dyb, in_data.ca, FRAC_BITS);
		nxt4.p_d0  = fx_mul(in_data.dxa, in_data.dyb, FRAC_BITS);
		nxt4.p_d1  = fx_mul(in_data.dxb, in_data.dya, FRAC_BITS);
	end

	// Stage five: differences and the zero determinant check.
	solve_t nxt5;
	always_comb begin
		nxt5.nx  = data_s4.p_nx0 - data_s4.p_nx1;
		nxt5.ny  = data_s4.p_ny0 - data_s4.p_ny1;
		nxt5.det = data_s4.p_d0 - data_s4.p_d1;
		nxt5.hit = data_s4.hit;
		nxt5.degenerate = data_s4.hit && (nxt5.det == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) data_s4 <= nxt4;
		if (en5) data_s5 <= nxt5;
	end

endmodule

FILE: rtl/sip_div.sv
// Pipelined restoring divider for both coordinates, one quotient bit a
// stage, with sign fix-up and result forming. Uses sip_pkg.
module sip_div
	import sip_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  solve_t     in_data,
	sip_chan_if.source res
);

	localparam int QW  = 32 + FRAC_BITS;
	localparam int NST = QW;

	typedef struct packed {
		logic [QW-1:0] num_x;
		logic [QW-1:0] num_y;
		logic [32:0]   rem_x;
		logic [32:0]   rem_y;
		logic [31:0]   q_x;
		logic [31:0]   q_y;
		logic [31:0]   dmag;
		logic          neg_x;
		logic          neg_y;
		logic          hit;
		logic          degenerate;
	} dstage_t;

	dstage_t div_q [NST+1];
	result_t out_q;
	logic    v_q [NST+2];
	logic    en [NST+3];

	// Ready chain from the output register back to the input.
	always_comb begin
		en[NST+2] = res.ready;
		for (int k = NST + 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end
	assign in_ready  = en[0];
	assign res.valid = v_q[NST+1];
	assign res.data  = out_q;

	// Entry stage: magnitudes and signs.
	dstage_t entry;
	always_comb begin
		logic [31:0] ax, ay;
		ax = in_data.nx[31] ? 32'(-in_data.nx) : 32'(in_data.nx);
		ay = in_data.ny[31] ? 32'(-in_data.ny) : 32'(in_data.ny);
		entry.num_x = QW'(ax) << FRAC_BITS;
		entry.num_y = QW'(ay) << FRAC_BITS;
		entry.rem_x = '0;
		entry.rem_y = '0;
		entry.q_x   = '0;
		entry.q_y   = '0;
		entry.dmag  = in_data.det[31] ? 32'(-in_data.det) : 32'(in_data.det);
		entry.neg_x = in_data.nx[31] ^ in_data.det[31];
		entry.neg_y = in_data.ny[31] ^ in_data.det[31];
		entry.hit   = in_data.hit;
		entry.degenerate = in_data.degenerate;
	end

	// One restoring step per stage; each later step reads only the registers of the stage before it.
	dstage_t step [NST+1];
	always_comb begin
		step[0] = entry;
		for (int k = 1; k <= NST; k++) begin
			logic [32:0] tx, ty;
			step[k] = div_q[k-1];
			tx = {div_q[k-1].rem_x[31:0], div_q[k-1].num_x[QW-k]};
			ty = {div_q[k-1].rem_y[31:0], div_q[k-1].num_y[QW-k]};
			if (tx >= {1'b0, div_q[k-1].dmag}) begin
				step[k].rem_x = tx - {1'b0, div_q[k-1].dmag};
				step[k].q_x   = {div_q[k-1].q_x[30:0], 1'b1};
			end else begin
				step[k].rem_x = tx;
				step[k].q_x   = {div_q[k-1].q_x[30:0], 1'b0};
			end
			if (ty >= {1'b0, div_q[k-1].dmag}) begin
				step[k].rem_y = ty - {1'b0, div_q[k-1].dmag};
				step[k].q_y   = {div_q[k-1].q_y[30:0], 1'b1};
			end else begin
				step[k].rem_y = ty;
				step[k].q_y   = {div_q[k-1].q_y[30:0], 1'b0};
			end
		end
	end

	// Output forming: sign fix-up, zero point on a miss or zero determinant.
	result_t fin;
	always_comb begin
		dstage_t l;
		l = div_q[NST];
		fin.hit        = l.hit;
		fin.degenerate = l.degenerate;
		if (l.hit && !l.degenerate) begin
			fin.cross_x = l.neg_x ? -l.q_x : l.q_x;
			fin.cross_y = l.neg_y ? -l.q_y : l.q_y;
		end else begin
			fin.cross_x = '0;
			fin.cross_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST + 1; k++) v_q[k] <= 1'b0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k <= NST + 1; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= NST; k++) begin
			if (en[k]) div_q[k] <= step[k];
		end
		if (en[NST+1]) out_q <= fin;
	end

endmodule

FILE: rtl/segment_intersection_point.sv
// Top level of the segment intersection pipeline.
// Uses sip_pkg, sip_chan_if, sip_front, sip_solve and sip_div.
//
//   channel  direction  payload     carries
//   seg      in         seg_pair_t  two segments and the mode bits
//   res      out        result_t    hit, point and degenerate flag
//
// One request enters per cycle while no stall holds the pipeline; the divider
// resolves one quotient bit per stage.
// Reset clears the valid bits only; no clearing pass is needed.
// A stall holds only the stages that are full, so bubbles close up and
// nothing is lost or repeated.
module segment_intersection_point
	import sip_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	sip_chan_if.sink   seg,
	sip_chan_if.source res
);

	logic       coef_valid, coef_ready;
	line_coef_t coef_data;
	logic       sol_valid, sol_ready;
	solve_t     sol_data;

	sip_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.out_valid (coef_valid),
		.out_ready (coef_ready),
		.out_data  (coef_data)
	);

	sip_solve #(.FRAC_BITS(FRAC_BITS)) u_solve (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coef_valid),
		.in_ready  (coef_ready),
		.in_data   (coef_data),
		.out_valid (sol_valid),
		.out_ready (sol_ready),
		.out_data  (sol_data)
	);

	sip_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sol_valid),
		.in_ready (sol_ready),
		.in_data  (sol_data),
		.res      (res)
	);

`ifndef SYNTHESIS
	// A miss carries a zero point and no degenerate flag.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.data.hit) |->
		(res.data.cross_x == 0 && res.data.cross_y == 0 && !res.data.degenerate))
		else $error("miss with non-zero payload");

	// A degenerate result is a hit with a zero point.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.degenerate) |->
		(res.data.hit && res.data.cross_x == 0 && res.data.cross_y == 0))
		else $error("degenerate result malformed");

	// The solver never flags a zero determinant on a miss.
	a_solve_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(sol_valid && sol_data.degenerate) |-> (sol_data.hit && sol_data.det == 0))
		else $error("solver degenerate flag inconsistent");
`endif

endmodule

FILE: tb/segment_intersection_point_test.sv
// Testbench for segment_intersection_point: drives segment pair requests,
// predicts each result in its own model and checks the result stream.
// Depends on sip_pkg, sip_chan_if and the segment_intersection_point RTL.
module segment_intersection_point_test
	import sip_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 12;
	localparam int LATENCY = 39 + FRAC;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sip_chan_if #(.payload_t(seg_pair_t)) seg ();
	sip_chan_if #(.payload_t(result_t)) res ();

	segment_intersection_point #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg),
		.res(res)
	);

	seg_pair_t pending_pairs[$];
	result_t expected_results[$];
	int errors = 0;
	longint cycles = 0;
	bit stimulus_done = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;

	// Clock generation.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Rounded multiply with a floor shift, wrapped to 32 bits.
	function automatic logic signed [31:0] round_mul(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + (64'sd1 <<< (FRAC - 1));
		p = p >>> FRAC;
		return p[31:0];
	endfunction

	// Sign of point p against the line from s0 to s1 (+1 when the cross is negative).
	function automatic int side_of(logic signed [31:0] s0x, logic signed [31:0] s0y,
			logic signed [31:0] s1x, logic signed [31:0] s1y,
			logic signed [31:0] px, logic signed [31:0] py);
		logic signed [31:0] c;
		c = round_mul(s1x - s0x, py - s0y) - round_mul(s1y - s0y, px - s0x);
		if (c < 0)
			return 1;
		if (c > 0)
			return -1;
		return 0;
	endfunction

	function automatic bit extents_apart(logic signed [31:0] a0, logic signed [31:0] a1,
			logic signed [31:0] b0, logic signed [31:0] b1);
		logic signed [31:0] amin, amax, bmin, bmax;
		amin = (a0 < a1) ? a0 : a1;
		amax = (a0 < a1) ? a1 : a0;
		bmin = (b0 < b1) ? b0 : b1;
		bmax = (b0 < b1) ? b1 : b0;
		return (amax < bmin) || (amin > bmax);
	endfunction

	// Truncating fixed-point divide, wrapped to 32 bits.
	function automatic logic signed [31:0] trunc_div(logic signed [31:0] n,
			logic signed [31:0] d);
		logic signed [63:0] q;
		q = (64'(n) * (64'sd1 <<< FRAC)) / 64'(d);
		return q[31:0];
	endfunction

	// Works out the intersection result of one segment pair.
	function automatic result_t predict_crossing(seg_pair_t s);
		result_t r;
		int pa, pb;
		logic signed [31:0] dxa, dya, ca, dxb, dyb, cb, nx, ny, det;
		r = '0;
		if (s.range_prefilter &&
				(extents_apart(s.a_start_x, s.a_end_x, s.b_start_x, s.b_end_x) ||
				extents_apart(s.a_start_y, s.a_end_y, s.b_start_y, s.b_end_y)))
			return r;
		pa = side_of(s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y, s.b_start_x, s.b_start_y)
			* side_of(s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y, s.b_end_x, s.b_end_y);
		pb = side_of(s.b_start_x, s.b_start_y, s.b_end_x, s.b_end_y, s.a_start_x, s.a_start_y)
			* side_of(s.b_start_x, s.b_start_y, s.b_end_x, s.b_end_y, s.a_end_x, s.a_end_y);
		if (s.touch_counts ? (pa > 0 || pb > 0) : (pa >= 0 || pb >= 0))
			return r;
		dxa = s.a_start_x - s.a_end_x;
		dya = s.a_end_y - s.a_start_y;
		ca = -(round_mul(dya, s.a_start_x) + round_mul(dxa, s.a_start_y));
		dxb = s.b_start_x - s.b_end_x;
		dyb = s.b_end_y - s.b_start_y;
		cb = -(round_mul(dyb, s.b_start_x) + round_mul(dxb, s.b_start_y));
		nx = round_mul(ca, dxb) - round_mul(cb, dxa);
		ny = round_mul(dya, cb) - round_mul(dyb, ca);
		det = round_mul(dxa, dyb) - round_mul(dxb, dya);
		r.hit = 1'b1;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		r.cross_x = trunc_div(nx, det);
		r.cross_y = trunc_div(ny, det);
		return r;
	endfunction

	function automatic logic signed [31:0] rand_coord(int kind);
		case (kind)
			0: return $signed($urandom);
			1: return $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
			2: return $signed($urandom_range(0, 32'h00010000)) - 32'sh00008000;
			default: return $signed($urandom_range(0, 16)) <<< FRAC;
		endcase
	endfunction

	function automatic seg_pair_t make_pair(logic signed [31:0] v[8], bit tc, bit pf);
		seg_pair_t s;
		s.a_start_x = v[0]; s.a_start_y = v[1]; s.a_end_x = v[2]; s.a_end_y = v[3];
		s.b_start_x = v[4]; s.b_start_y = v[5]; s.b_end_x = v[6]; s.b_end_y = v[7];
		s.touch_counts = tc;
		s.range_prefilter = pf;
		return s;
	endfunction

	// Stimulus: directed pairs in every mode, then random pairs.
	initial begin
		logic signed [31:0] v[8];
		logic signed [31:0] one;
		int kind;
		one = 32'sd1 <<< FRAC;
		for (int m = 0; m < 4; m++) begin
			// Proper crossing of two diagonals.
			v = '{0, 0, 4*one, 4*one, 0, 4*one, 4*one, 0};
			pending_pairs.push_back(make_pair(v, m[0], m[1]));
			// Endpoint touching the other segment.
			v = '{0, 0, 4*one, 0, 2*one, 0, 2*one, 3*one};
			pending_pairs.push_back(make_pair(v, m[0], m[1]));
			// Collinear overlap, which gives a zero determinant when it counts.
			v = '{0, 0, 4*one, 0, one, 0, 6*one, 0};
			pending_pairs.push_back(make_pair(v, m[0], m[1]));
			// Collinear but far apart, so in touch-counting mode only the prefilter rejects it.
			v = '{0, 0, one, 0, 8*one, 0, 9*one, 0};
			pending_pairs.push_back(make_pair(v, m[0], m[1]));
			// Extreme coordinates that wrap.
			v = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
				32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
			pending_pairs.push_back(make_pair(v, m[0], m[1]));
			v = '{-1, -1, -1, -1, 0, 0, 0, 0};
			pending_pairs.push_back(make_pair(v, m[0], m[1]));
		end
		for (int n = 0; n < 1600; n++) begin
			kind = $urandom_range(0, 3);
			for (int k = 0; k < 8; k++)
				v[k] = rand_coord(kind);
			// Some pairs share an endpoint.
			if ($urandom_range(0, 9) == 0) begin
				v[4] = v[2];
				v[5] = v[3];
			end
			pending_pairs.push_back(make_pair(v, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1))));
		end
		stimulus_done = 1'b1;
	end

	// Driver: presents queued requests with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg.valid <= 1'b0;
			seg.data <= '0;
			send_wait <= 0;
		end else begin
			if (seg.valid && seg.ready) begin
				expected_results.push_back(predict_crossing(seg.data));
			end
			if (!seg.valid || seg.ready) begin
				if (send_wait > 0) begin
					seg.valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pending_pairs.size() > 0) begin
					seg.valid <= 1'b1;
					seg.data <= pending_pairs.pop_front();
					send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
				end else begin
					seg.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure and comparison with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected: %p", $realtime, res.data);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (res.data.hit !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b", $realtime, want.hit,
							res.data.hit);
						errors++;
					end
					if (res.data.cross_x !== want.cross_x) begin
						$display("%0t: cross_x expected %0d actual %0d", $realtime,
							want.cross_x, res.data.cross_x);
						errors++;
					end
					if (res.data.cross_y !== want.cross_y) begin
						$display("%0t: cross_y expected %0d actual %0d", $realtime,
							want.cross_y, res.data.cross_y);
						errors++;
					end
					if (res.data.degenerate !== want.degenerate) begin
						$display("%0t: degenerate expected %0b actual %0b", $realtime,
							want.degenerate, res.data.degenerate);
						errors++;
					end
				end
			end
			if (recv_wait > 0) begin
				res.ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else begin
				res.ready <= 1'b1;
				recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			end
		end
	end

	// Cycle counter with a generous limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("segment_intersection_point test failed");
			$finish;
		end
	end

	// Reset, then wait for the stream to drain.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done);
		while (pending_pairs.size() > 0 || seg.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("segment_intersection_point test passed");
		else
			$display("segment_intersection_point test failed");
		$finish;
	end

endmodule
